/* rtl/ble_pkg.sv */
// shared constants and types of the bounded list engine
package ble_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int WORD_W   = 64;

   localparam logic [3:0] CMD_CLEAR    = 4'd0;
   localparam logic [3:0] CMD_APPEND   = 4'd1;
   localparam logic [3:0] CMD_APPEND_U = 4'd2;
   localparam logic [3:0] CMD_PUSH     = 4'd3;
   localparam logic [3:0] CMD_REMOVE   = 4'd4;
   localparam logic [3:0] CMD_POP      = 4'd5;
   localparam logic [3:0] CMD_CONTAINS = 4'd6;
   localparam logic [3:0] CMD_READ_AT  = 4'd7;
   localparam logic [3:0] CMD_SORT     = 4'd8;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [3:0]        cmd;
      logic [WORD_W-1:0] value;
      logic [5:0]        index;
   } cmd_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] value_out;
      logic [CNT_W-1:0]  count;
   } result_type;

endpackage

/* rtl/bounded_list_engine.sv */
// top level: stream ports, command capture and result output register
//
// channel | ports            | transfer
// req     | req_tvalid/tready | one command (cmd, value, index)
// rsp     | rsp_tvalid/tready | one result (status, value_out, count)
//
// clear, append, full and range misses finish straight from idle; search, push,
// remove and pop step through the entries and sort through pairs of entries,
// all paced by the single store read port and the shared compare unit.
// req_tready is high only while the sequencer is idle; synchronous reset
// empties the list; a stalled rsp holds the finished result in the sequencer.
module bounded_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // cmd[3:0], value[67:4], index[73:68]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // status[1:0], value_out[65:2], count[72:66]
);

   ble_pkg::cmd_type    cmd;
   ble_pkg::result_type result;
   ble_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                idle, done, done_ack;

   assign cmd.cmd   = req_tdata[3:0];
   assign cmd.value = req_tdata[67:4];
   assign cmd.index = req_tdata[73:68];

   assign done_ack = done && (!rsp_valid_ff || rsp_tready);

   ble_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && idle),
      .cmd_in   (cmd),
      .idle     (idle),
      .done     (done),
      .done_ack (done_ack),
      .result   (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_ack) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_tready = idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.count, rsp_ff.value_out, rsp_ff.status};

endmodule

/* rtl/ble_ram.sv */
// entry store: one write port, one registered read port
module ble_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ble_pkg::ADDR_W-1:0]     wr_addr,
   input  logic [ble_pkg::WORD_W-1:0]     wr_data,
   input  logic [ble_pkg::ADDR_W-1:0]     rd_addr,
   output logic [ble_pkg::WORD_W-1:0]     rd_data
);

   logic [ble_pkg::WORD_W-1:0] mem [ble_pkg::CAPACITY];
   logic [ble_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ble_core.sv */
// command sequencer with one shared compare unit over the entry store
module ble_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ble_pkg::cmd_type      cmd_in,
   output logic                  idle,
   output logic                  done,
   input  logic                  done_ack,
   output ble_pkg::result_type   result
);

   localparam int AW = ble_pkg::ADDR_W;
   localparam int CW = ble_pkg::CNT_W;
   localparam int WW = ble_pkg::WORD_W;
   localparam logic [CW-1:0] CAP = CW'(ble_pkg::CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND_RD, S_FIND_CMP, S_SHU_RD, S_SHU_WR, S_SHD_RD, S_SHD_WR,
      S_RD_WAIT, S_SI_RD, S_SI_LD, S_SJ_RD, S_SJ_CMP, S_SI_WR, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         cmd_ff, cmd_in_r;
   logic [WW-1:0]      hold_ff, hold_in;
   logic [WW-1:0]      vout_ff, vout_in;
   logic [1:0]         status_ff, status_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [WW-1:0]      wr_data, rd_data;
   logic               cmp_eq, cmp_gt;

   ble_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit
   assign cmp_eq = (hold_ff == rd_data);
   assign cmp_gt = (hold_ff > rd_data);

   always_comb begin
      state_in  = state_ff;
      cmd_in_r  = cmd_ff;
      hold_in   = hold_ff;
      vout_in   = vout_ff;
      status_in = status_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      wr_en     = 1'b0;
      wr_addr   = i_ff[AW-1:0];
      wr_data   = hold_ff;
      rd_addr   = i_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in_r  = cmd_in.cmd;
               hold_in   = cmd_in.value;
               vout_in   = '0;
               status_in = ble_pkg::ST_OK;
               i_in      = '0;
               j_in      = '0;
               state_in  = S_DONE;
               unique case (cmd_in.cmd)
                  ble_pkg::CMD_CLEAR: count_in = '0;
                  ble_pkg::CMD_APPEND: begin
                     if (count_ff >= CAP) begin
                        status_in = ble_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = cmd_in.value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ble_pkg::CMD_APPEND_U, ble_pkg::CMD_REMOVE,
                  ble_pkg::CMD_CONTAINS: state_in = S_FIND_RD;
                  ble_pkg::CMD_PUSH: begin
                     if (count_ff >= CAP) begin
                        status_in = ble_pkg::ST_FULL;
                     end else begin
                        i_in     = count_ff;
                        state_in = S_SHU_RD;
                     end
                  end
                  ble_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = ble_pkg::ST_MISS;
                     end else begin
                        rd_addr  = '0;
                        state_in = S_RD_WAIT;
                     end
                  end
                  ble_pkg::CMD_READ_AT: begin
                     if (CW'(cmd_in.index) >= count_ff) begin
                        status_in = ble_pkg::ST_RANGE;
                     end else begin
                        i_in     = CW'(cmd_in.index);
                        rd_addr  = cmd_in.index;
                        state_in = S_RD_WAIT;
                     end
                  end
                  ble_pkg::CMD_SORT: state_in = S_SI_RD;
                  default: ;
               endcase
            end
         end
         S_FIND_RD: begin
            if (i_ff >= count_ff) begin
               priority if (cmd_ff == ble_pkg::CMD_APPEND_U) begin
                  if (count_ff >= CAP) begin
                     status_in = ble_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  status_in = ble_pkg::ST_MISS;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (cmp_eq) begin
               priority if (cmd_ff == ble_pkg::CMD_REMOVE) begin
                  j_in     = i_ff;
                  state_in = S_SHD_RD;
               end else if (cmd_ff == ble_pkg::CMD_APPEND_U) begin
                  status_in = ble_pkg::ST_MISS;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_SHU_RD: begin
            if (i_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = AW'(i_ff - 1'b1);
               state_in = S_SHU_WR;
            end
         end
         S_SHU_WR: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[AW-1:0];
            wr_data  = rd_data;
            i_in     = i_ff - 1'b1;
            state_in = S_SHU_RD;
         end
         S_SHD_RD: begin
            if (j_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = AW'(j_ff + 1'b1);
               state_in = S_SHD_WR;
            end
         end
         S_SHD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            wr_data  = rd_data;
            j_in     = j_ff + 1'b1;
            state_in = S_SHD_RD;
         end
         S_RD_WAIT: begin
            vout_in = rd_data;
            if (cmd_ff == ble_pkg::CMD_POP) begin
               j_in     = '0;
               state_in = S_SHD_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SI_RD: begin
            if (i_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SI_LD;
            end
         end
         S_SI_LD: begin
            hold_in  = rd_data;
            j_in     = i_ff + 1'b1;
            state_in = (i_ff + 1'b1 >= count_ff) ? S_SI_WR : S_SJ_RD;
         end
         S_SJ_RD: begin
            rd_addr  = j_ff[AW-1:0];
            state_in = S_SJ_CMP;
         end
         S_SJ_CMP: begin
            if (cmp_gt) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = hold_ff;
               hold_in = rd_data;
            end
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 >= count_ff) ? S_SI_WR : S_SJ_RD;
         end
         S_SI_WR: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[AW-1:0];
            i_in     = i_ff + 1'b1;
            state_in = S_SI_RD;
         end
         S_DONE: begin
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cmd_ff    <= cmd_in_r;
      hold_ff   <= hold_in;
      vout_ff   <= vout_in;
      status_ff <= status_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
   end

   assign idle             = (state_ff == S_IDLE);
   assign done             = (state_ff == S_DONE);
   assign result.status    = status_ff;
   assign result.value_out = vout_ff;
   assign result.count     = count_ff;

endmodule
